>>> hdl/tls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tls_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned ResIdxW    = $clog2(MaxResults);
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharQuote = 8'h27;
  localparam logic [7:0] CharSemi  = 8'h3B;
  localparam logic [7:0] CharComma = 8'h2C;

  typedef enum logic [2:0] {
    MODE_IDLE       = 3'd0,
    MODE_IDENT      = 3'd1,
    MODE_INT        = 3'd2,
    MODE_FLOAT_DOT  = 3'd3,
    MODE_FLOAT_FRAC = 3'd4,
    MODE_QUOTE_OPEN = 3'd5,
    MODE_QUOTE_ONE  = 3'd6,
    MODE_QUOTE_MANY = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_SEP    = 3'd1,
    KIND_INT    = 3'd2,
    KIND_FLOAT  = 3'd3,
    KIND_CHAR   = 3'd4,
    KIND_STRING = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } token_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic [2:0] token_kind;
    logic       last;
  } token_out_t;

  // All results caused by one input character.
  typedef struct packed {
    logic [ResCntW-1:0]                count;
    token_out_t [MaxResults-1:0]       res;
  } bundle_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

`default_nettype wire

>>> hdl/token_lexer_stream.sv
// Streaming lexer: one character per transaction in, token bytes and token ends out.
// The first result of a character passes the bundle queue and then the output register.
// Throughput: one character per cycle while each yields at most one result and pop is
// held; the output register drains one result per cycle while pop is held.
// Reset (rst_ni low, asynchronous): lexer mode idle, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none

module token_lexer_stream (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // character side
  input  wire logic               push,
  output logic                    full,
  input  wire tls_pkg::token_in_t in_i,
  // result side
  output logic                    empty,
  input  wire logic               pop,
  output tls_pkg::token_out_t     out_o
);
  import tls_pkg::*;

  logic     accept;
  logic     q_push, q_pop;
  bundle_t  q_wdata, q_head;
  q_stat_t  q_stat;

  // Front end holds the lexer mode and turns each character into a bundle of
  // up to four results. Characters with no result never touch the queue.
  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  tls_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_i),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // Two-entry bundle queue decouples the lexer from the result drain.
  tls_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // Back end walks a bundle into the output register, one result per cycle while that
  // register is free or popped, marking the final one as last, and frees the entry with it.
  tls_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (q_head),
    .q_empty_i (q_stat.empty),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

>>> hdl/tls_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tls_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire tls_pkg::token_in_t in_i,
  output logic                    q_push_o,
  output tls_pkg::bundle_t        q_data_o
);
  import tls_pkg::*;

  mode_e   mode_q, mode_d;
  bundle_t bnd;
  logic    restart;
  logic [7:0] c;

  function automatic bundle_t add_byte(bundle_t b, logic [7:0] v);
    bundle_t r;
    r = b;
    r.res[b.count[ResIdxW-1:0]].out_byte   = v;
    r.res[b.count[ResIdxW-1:0]].byte_valid = 1'b1;
    r.count = b.count + ResCntW'(1);
    return r;
  endfunction

  function automatic bundle_t add_end(bundle_t b, kind_e k);
    bundle_t r;
    r = b;
    r.res[b.count[ResIdxW-1:0]].token_end  = 1'b1;
    r.res[b.count[ResIdxW-1:0]].token_kind = k;
    r.count = b.count + ResCntW'(1);
    return r;
  endfunction

  assign c = in_i.char_byte;

  // Open token is closed by this character; it is then taken as in idle.
  always_comb begin
    restart = 1'b0;
    if (!in_i.end_of_input) begin
      unique case (mode_q)
        MODE_IDENT:      restart = !(is_alpha(c) || is_digit(c));
        MODE_INT:        restart = !is_digit(c) && (c != CharDot);
        MODE_FLOAT_DOT,
        MODE_FLOAT_FRAC: restart = !is_digit(c);
        MODE_QUOTE_OPEN,
        MODE_QUOTE_ONE,
        MODE_QUOTE_MANY: restart = 1'b0;
        default:         restart = 1'b1;
      endcase
    end
  end

  // Next state
  always_comb begin
    mode_d = mode_q;
    if (in_i.end_of_input) begin
      mode_d = MODE_IDLE;
    end else if (restart) begin
      if (is_alpha(c)) begin
        mode_d = MODE_IDENT;
      end else if (is_digit(c)) begin
        mode_d = MODE_INT;
      end else if (c == CharDot) begin
        mode_d = MODE_FLOAT_DOT;
      end else if (c == CharQuote) begin
        mode_d = MODE_QUOTE_OPEN;
      end else begin
        mode_d = MODE_IDLE;
      end
    end else begin
      unique case (mode_q)
        MODE_INT: begin
          if (c == CharDot) begin
            mode_d = MODE_FLOAT_DOT;
          end
        end
        MODE_FLOAT_DOT:  mode_d = MODE_FLOAT_FRAC;
        MODE_QUOTE_OPEN: mode_d = (c == CharQuote) ? MODE_IDLE : MODE_QUOTE_ONE;
        MODE_QUOTE_ONE:  mode_d = (c == CharQuote) ? MODE_IDLE : MODE_QUOTE_MANY;
        MODE_QUOTE_MANY: begin
          if (c == CharQuote) begin
            mode_d = MODE_IDLE;
          end
        end
        default:         mode_d = mode_q;
      endcase
    end
  end

  // Results
  always_comb begin
    bnd = '0;
    if (in_i.end_of_input) begin
      unique case (mode_q)
        MODE_IDENT:      bnd = add_end(bnd, KIND_IDENT);
        MODE_INT:        bnd = add_end(bnd, KIND_INT);
        MODE_FLOAT_DOT:  bnd = add_end(add_byte(bnd, CharZero), KIND_FLOAT);
        MODE_FLOAT_FRAC: bnd = add_end(bnd, KIND_FLOAT);
        MODE_QUOTE_OPEN,
        MODE_QUOTE_ONE,
        MODE_QUOTE_MANY: bnd = add_end(bnd, KIND_ERROR);
        default:         bnd = '0;
      endcase
    end else begin
      unique case (mode_q)
        MODE_IDENT:      bnd = restart ? add_end(bnd, KIND_IDENT) : add_byte(bnd, c);
        MODE_INT:        bnd = restart ? add_end(bnd, KIND_INT) : add_byte(bnd, c);
        MODE_FLOAT_DOT:  bnd = restart ? add_end(add_byte(bnd, CharZero), KIND_FLOAT)
                                       : add_byte(bnd, c);
        MODE_FLOAT_FRAC: bnd = restart ? add_end(bnd, KIND_FLOAT) : add_byte(bnd, c);
        MODE_QUOTE_OPEN,
        MODE_QUOTE_ONE:  bnd = (c == CharQuote) ? add_end(bnd, KIND_CHAR) : add_byte(bnd, c);
        MODE_QUOTE_MANY: bnd = (c == CharQuote) ? add_end(bnd, KIND_STRING)
                                                : add_byte(bnd, c);
        default:         bnd = '0;
      endcase

      // Start of a new token, also after one has just been closed.
      if (restart) begin
        if (is_alpha(c) || is_digit(c)) begin
          bnd = add_byte(bnd, c);
        end else if (c == CharDot) begin
          bnd = add_byte(add_byte(bnd, CharZero), CharDot);
        end else if ((c == CharSemi) || (c == CharComma)) begin
          bnd = add_end(add_byte(bnd, c), KIND_SEP);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

  assign q_push_o = accept_i && (bnd.count != '0);
  assign q_data_o = bnd;

endmodule

`default_nettype wire

>>> hdl/tls_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module tls_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire tls_pkg::bundle_t data_i,
  input  wire logic             pop_i,
  output tls_pkg::bundle_t      head_o,
  output tls_pkg::q_stat_t      stat_o
);
  import tls_pkg::*;

  bundle_t              entries_q [QueueDepth];
  logic [QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  assign head_o       = entries_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QCntW'(QueueDepth));

endmodule

`default_nettype wire

>>> hdl/tls_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tls_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tls_pkg::bundle_t head_i,
  input  wire logic             q_empty_i,
  output logic                  q_pop_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output tls_pkg::token_out_t   out_o
);
  import tls_pkg::*;

  logic [ResIdxW-1:0] idx_q, idx_d;
  logic               valid_q, valid_d;
  token_out_t         out_q, item;
  logic               load, is_last;

  assign load    = !q_empty_i && (!valid_q || pop_i);
  assign is_last = ({1'b0, idx_q} == (head_i.count - ResCntW'(1)));

  always_comb begin
    item      = head_i.res[idx_q];
    item.last = is_last;
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + ResIdxW'(1);
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= item;
    end
  end

  assign q_pop_o = load && is_last;
  assign empty_o = !valid_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import tls_pkg::*;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push   = 1'b0;
  logic       full;
  token_in_t  in_i   = '0;
  logic       empty;
  logic       pop    = 1'b0;
  token_out_t out_o;

  token_lexer_stream dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Characters still to be offered, and token output predicted but not yet seen.
  token_in_t  char_q[$];
  token_out_t tok_q[$];
  int         errors = 0;

  // ---------------------------------------------------------------------------
  // Lexer predictor. Holds its own mode; every accepted transaction is run
  // through it and the resulting token items are appended to tok_q. The most
  // recent item of a step is held back so its last flag can be set once the
  // step is complete.
  // ---------------------------------------------------------------------------
  mode_e      lex_mode = MODE_IDLE;
  token_out_t held;
  bit         have_held = 1'b0;

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // space, tab, LF, VT, FF, CR
  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  task automatic stage(token_out_t r);
    if (have_held) tok_q = {tok_q, held};
    held      = r;
    have_held = 1'b1;
  endtask

  task automatic emit_byte(logic [7:0] b);
    token_out_t r;
    r            = '0;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    stage(r);
  endtask

  task automatic emit_end(kind_e kind);
    token_out_t r;
    r            = '0;
    r.token_end  = 1'b1;
    r.token_kind = kind;
    stage(r);
  endtask

  // Character seen with no token open.
  task automatic open_token(logic [7:0] c);
    lex_mode = MODE_IDLE;
    if (is_blank(c)) begin
      // skipped
    end else if (is_letter(c)) begin
      emit_byte(c);
      lex_mode = MODE_IDENT;
    end else if (is_numeral(c)) begin
      emit_byte(c);
      lex_mode = MODE_INT;
    end else if (c == CharDot) begin
      // float with no integer part gets a leading zero
      emit_byte(CharZero);
      emit_byte(CharDot);
      lex_mode = MODE_FLOAT_DOT;
    end else if (c == CharQuote) begin
      lex_mode = MODE_QUOTE_OPEN;
    end else if (c == CharSemi || c == CharComma) begin
      emit_byte(c);
      emit_end(KIND_SEP);
    end
    // anything else is unknown and dropped
  endtask

  task automatic lex_step(token_in_t item);
    logic [7:0] c;
    c = item.char_byte;
    if (item.end_of_input) begin
      case (lex_mode)
        MODE_IDENT:      emit_end(KIND_IDENT);
        MODE_INT:        emit_end(KIND_INT);
        MODE_FLOAT_DOT: begin
          emit_byte(CharZero);
          emit_end(KIND_FLOAT);
        end
        MODE_FLOAT_FRAC: emit_end(KIND_FLOAT);
        MODE_QUOTE_OPEN,
        MODE_QUOTE_ONE,
        MODE_QUOTE_MANY: emit_end(KIND_ERROR);
        default: ;
      endcase
      lex_mode = MODE_IDLE;
    end else begin
      case (lex_mode)
        MODE_IDENT: begin
          if (is_letter(c) || is_numeral(c)) begin
            emit_byte(c);
          end else begin
            emit_end(KIND_IDENT);
            open_token(c);
          end
        end
        MODE_INT: begin
          if (is_numeral(c)) begin
            emit_byte(c);
          end else if (c == CharDot) begin
            emit_byte(c);
            lex_mode = MODE_FLOAT_DOT;
          end else begin
            emit_end(KIND_INT);
            open_token(c);
          end
        end
        MODE_FLOAT_DOT: begin
          if (is_numeral(c)) begin
            emit_byte(c);
            lex_mode = MODE_FLOAT_FRAC;
          end else begin
            // no fraction digits: trailing zero
            emit_byte(CharZero);
            emit_end(KIND_FLOAT);
            open_token(c);
          end
        end
        MODE_FLOAT_FRAC: begin
          if (is_numeral(c)) begin
            emit_byte(c);
          end else begin
            emit_end(KIND_FLOAT);
            open_token(c);
          end
        end
        MODE_QUOTE_OPEN, MODE_QUOTE_ONE: begin
          // closing quote is consumed; zero or one byte makes a character token
          if (c == CharQuote) begin
            emit_end(KIND_CHAR);
            lex_mode = MODE_IDLE;
          end else begin
            emit_byte(c);
            lex_mode = (lex_mode == MODE_QUOTE_OPEN) ? MODE_QUOTE_ONE : MODE_QUOTE_MANY;
          end
        end
        MODE_QUOTE_MANY: begin
          if (c == CharQuote) begin
            emit_end(KIND_STRING);
            lex_mode = MODE_IDLE;
          end else begin
            emit_byte(c);
          end
        end
        default: open_token(c);
      endcase
    end
    if (have_held) begin
      held.last = 1'b1;
      tok_q = {tok_q, held};
      have_held = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle bursts. Each side redraws its idle level at its own value of cyc[5:0];
  // level 0 gives a stretch with no idling. Near stimulus end nothing idles.
  // ---------------------------------------------------------------------------
  int unsigned cyc = 0;
  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic bit idle_now(int unsigned level);
    if (char_q.size() < 40 || level == 0) return 1'b0;
    return $urandom_range(0, level * 3) == 0;
  endfunction

  // Character driver: a transaction completes on push && !full.
  int unsigned drv_gap   = 0;
  int unsigned drv_level = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push    <= 1'b0;
      in_i    <= '0;
      drv_gap = 0;
    end else begin
      if (cyc[5:0] == 6'd0) drv_level = $urandom_range(0, 3);
      if (!(push && full)) begin
        if (push) lex_step(in_i);
        if (drv_gap > 0) begin
          drv_gap--;
          push <= 1'b0;
        end else if (char_q.size() > 0 && idle_now(drv_level)) begin
          drv_gap = $urandom_range(0, 3);
          push    <= 1'b0;
        end else if (char_q.size() > 0) begin
          push <= 1'b1;
          in_i <= char_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Token monitor: a transaction completes on pop && !empty.
  int unsigned mon_gap   = 0;
  int unsigned mon_level = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    token_out_t want;
    if (!rst_ni) begin
      pop     <= 1'b0;
      mon_gap = 0;
    end else begin
      if (cyc[5:0] == 6'd32) mon_level = $urandom_range(0, 3);
      if (pop && !empty) begin
        if (tok_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected token item: byte %02h bv %0b end %0b kind %0d last %0b",
                     out_o.out_byte, out_o.byte_valid, out_o.token_end,
                     out_o.token_kind, out_o.last);
        end else begin
          want = tok_q.pop_front();
          if (out_o.out_byte !== want.out_byte || out_o.byte_valid !== want.byte_valid ||
              out_o.token_end !== want.token_end || out_o.token_kind !== want.token_kind ||
              out_o.last !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %02h/%0b/%0b/%0d/%0b got %02h/%0b/%0b/%0d/%0b",
                       want.out_byte, want.byte_valid, want.token_end, want.token_kind,
                       want.last, out_o.out_byte, out_o.byte_valid, out_o.token_end,
                       out_o.token_kind, out_o.last);
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap--;
        pop <= 1'b0;
      end else if (idle_now(mon_level)) begin
        mon_gap = $urandom_range(0, 3);
        pop     <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_char(logic [7:0] c);
    token_in_t t;
    t.char_byte    = c;
    t.end_of_input = 1'b0;
    char_q = {char_q, t};
  endtask

  // char_byte is random here: it must be ignored
  task automatic add_eoi();
    token_in_t t;
    t.char_byte    = 8'($urandom_range(0, 255));
    t.end_of_input = 1'b1;
    char_q = {char_q, t};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25))
                                : 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_numeral();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13));
  endfunction

  task automatic gen_random(int unsigned target);
    int unsigned counted;
    int unsigned n;
    logic [7:0]  b;
    counted = 0;
    while (counted < target) begin
      case ($urandom_range(0, 9))
        0, 1: begin // identifier
          add_char(rand_letter());
          n = $urandom_range(0, 6);
          for (int i = 0; i < n; i++)
            add_char($urandom_range(0, 2) == 0 ? rand_numeral() : rand_letter());
          counted += n + 1;
        end
        2: begin // integer
          n = $urandom_range(1, 5);
          for (int i = 0; i < n; i++) add_char(rand_numeral());
          counted += n;
        end
        3: begin // float, with or without either digit run
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) add_char(rand_numeral());
          add_char(CharDot);
          counted += n + 1;
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) add_char(rand_numeral());
          counted += n;
        end
        4, 5: begin // quoted run of arbitrary bytes, sometimes left open
          add_char(CharQuote);
          n = $urandom_range(0, 5);
          for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            add_char(b == CharQuote ? 8'h7E : b);
          end
          if ($urandom_range(0, 5) == 0) add_eoi();
          else add_char(CharQuote);
          counted += n + 2;
        end
        6: begin
          add_char($urandom_range(0, 1) ? CharSemi : CharComma);
          counted++;
        end
        7: begin
          add_char(rand_blank());
          counted++;
        end
        8: begin // noise
          add_char(8'($urandom_range(0, 255)));
          counted++;
        end
        default: begin
          add_eoi();
          counted++;
        end
      endcase
    end
  endtask

  initial begin
    // Directed: separators, identifier/integer/float ends, leading and trailing
    // zero on floats, empty and single-character quotes, unclosed quote at end
    // of input, end of input in idle and after a bare dot, blanks, unknowns.
    add_text("ab1;");
    add_text("12.5,");
    add_text(".x");
    add_eoi();
    add_text("''");
    add_text("'a'");
    add_char(CharQuote);
    add_char(8'hFF);
    add_char(8'h00);
    add_eoi();
    add_text("7.");
    add_eoi();
    add_eoi();
    add_char(8'h00);
    add_char(8'hFF);
    add_text("\tZ9 ");
    add_text("'Zz'");

    gen_random(375);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_q.size() > 0 || push) @(posedge clk_i);
    while (tok_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> token_lexer_stream.f
hdl/tls_pkg.sv
hdl/tls_front.sv
hdl/tls_queue.sv
hdl/tls_back.sv
hdl/token_lexer_stream.sv
sim/tb.sv
